// File: hw/rtl/mtsd_pkg.sv
// Shared types and constants for the Morse tone stream decoder.
// Holds the item structs, the result bundle and the Morse symbol table.
// Depends on nothing.
package mtsd_pkg;

   localparam int UNITS_W       = 13;
   localparam int CHAR_W        = 7;
   localparam int RESULTS_MAX   = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int MORSE_ENTRIES = 42;

   localparam logic [UNITS_W-1:0] UNITS_RESET  = 13'd1;
   localparam logic [CHAR_W-1:0]  CHAR_UNKNOWN = 7'h3F;   // '?'
   localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 7'h20;   // ' '

   typedef struct packed {
      logic tone_on;
      logic end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last_result;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                       count;
      rsp_item_type [RESULTS_MAX-1:0]   items;
   } step_result_type;

   // length, pattern (1 = dash, newest element in bit 0), ASCII code
   typedef struct packed {
      logic [2:0]        len;
      logic [5:0]        bits;
      logic [CHAR_W-1:0] ch;
   } morse_entry_type;

   localparam morse_entry_type MORSE_TABLE [MORSE_ENTRIES] = '{
      '{3'd2, 6'b000001, 7'h41}, '{3'd4, 6'b001000, 7'h42}, '{3'd4, 6'b001010, 7'h43},
      '{3'd3, 6'b000100, 7'h44}, '{3'd1, 6'b000000, 7'h45}, '{3'd4, 6'b000010, 7'h46},
      '{3'd3, 6'b000110, 7'h47}, '{3'd4, 6'b000000, 7'h48}, '{3'd2, 6'b000000, 7'h49},
      '{3'd4, 6'b000111, 7'h4A}, '{3'd3, 6'b000101, 7'h4B}, '{3'd4, 6'b000100, 7'h4C},
      '{3'd2, 6'b000011, 7'h4D}, '{3'd2, 6'b000010, 7'h4E}, '{3'd3, 6'b000111, 7'h4F},
      '{3'd4, 6'b000110, 7'h50}, '{3'd4, 6'b001101, 7'h51}, '{3'd3, 6'b000010, 7'h52},
      '{3'd3, 6'b000000, 7'h53}, '{3'd1, 6'b000001, 7'h54}, '{3'd3, 6'b000001, 7'h55},
      '{3'd4, 6'b000001, 7'h56}, '{3'd3, 6'b000011, 7'h57}, '{3'd4, 6'b001001, 7'h58},
      '{3'd4, 6'b001011, 7'h59}, '{3'd4, 6'b001100, 7'h5A},
      '{3'd5, 6'b011111, 7'h30}, '{3'd5, 6'b001111, 7'h31}, '{3'd5, 6'b000111, 7'h32},
      '{3'd5, 6'b000011, 7'h33}, '{3'd5, 6'b000001, 7'h34}, '{3'd5, 6'b000000, 7'h35},
      '{3'd5, 6'b010000, 7'h36}, '{3'd5, 6'b011000, 7'h37}, '{3'd5, 6'b011100, 7'h38},
      '{3'd5, 6'b011110, 7'h39},
      '{3'd5, 6'b001010, 7'h2B}, '{3'd5, 6'b010010, 7'h2F}, '{3'd6, 6'b010101, 7'h2E},
      '{3'd6, 6'b111000, 7'h3A}, '{3'd6, 6'b100001, 7'h2D}, '{3'd6, 6'b001100, 7'h3F}
   };

endpackage

// File: hw/rtl/mtsd_step.sv
// Per-sample decode logic: run tracking, element classification and lookup.
// Purely combinational; uses mtsd_pkg for item types and the symbol table.
module mtsd_step #(
   parameter int MAX_ELEMENTS   = 6,
   parameter int RUN_COUNT_BITS = 16,
   parameter int CNT_W          = $clog2(MAX_ELEMENTS + 2)
) (
   input  mtsd_pkg::req_item_type        item,
   input  logic [mtsd_pkg::UNITS_W-1:0]  units,
   input  logic                          started,
   input  logic                          level,
   input  logic [RUN_COUNT_BITS-1:0]     length,
   input  logic [MAX_ELEMENTS-1:0]       pbits,
   input  logic [CNT_W-1:0]              pcnt,
   output logic                          nxt_started,
   output logic                          nxt_level,
   output logic [RUN_COUNT_BITS-1:0]     nxt_length,
   output logic [MAX_ELEMENTS-1:0]       nxt_pbits,
   output logic [CNT_W-1:0]              nxt_pcnt,
   output mtsd_pkg::step_result_type     result
);
   import mtsd_pkg::*;

   localparam int CMP_W = (RUN_COUNT_BITS > 16) ? RUN_COUNT_BITS : 16;

   typedef struct packed {
      logic [MAX_ELEMENTS-1:0] bits;
      logic [CNT_W-1:0]        cnt;
      logic                    emit_char;
      logic [CHAR_W-1:0]       ch;
      logic                    emit_space;
   } close_type;

   function automatic logic [CHAR_W-1:0] decode(input logic [MAX_ELEMENTS-1:0] bits,
                                                input logic [CNT_W-1:0] cnt);
      logic [CHAR_W-1:0] ch;
      ch = CHAR_UNKNOWN;
      if (cnt <= CNT_W'(MAX_ELEMENTS)) begin
         for (int i = 0; i < MORSE_ENTRIES; i++) begin
            if (8'(cnt) == 8'(MORSE_TABLE[i].len) && 8'(bits) == 8'(MORSE_TABLE[i].bits))
               ch = MORSE_TABLE[i].ch;
         end
      end
      return ch;
   endfunction

   function automatic close_type close_run(input logic lvl,
                                           input logic [CMP_W-1:0] len,
                                           input logic [CMP_W-1:0] two,
                                           input logic [CMP_W-1:0] five,
                                           input logic [MAX_ELEMENTS-1:0] bits,
                                           input logic [CNT_W-1:0] cnt);
      close_type r;
      logic      flush;
      r.bits       = bits;
      r.cnt        = cnt;
      r.emit_char  = 1'b0;
      r.ch         = decode(bits, cnt);
      r.emit_space = 1'b0;
      flush        = 1'b0;
      if (lvl) begin
         if (cnt < CNT_W'(MAX_ELEMENTS)) begin
            r.bits = {bits[MAX_ELEMENTS-2:0], (len >= two)};
            r.cnt  = cnt + CNT_W'(1);
         end else begin
            r.cnt = CNT_W'(MAX_ELEMENTS + 1);   // overflowed pattern
         end
      end else if (len >= two) begin
         flush        = 1'b1;
         r.emit_space = (len >= five);
      end
      if (flush && cnt != '0) begin
         r.emit_char = 1'b1;
         r.bits      = '0;
         r.cnt       = '0;
      end
      return r;
   endfunction

   logic [CMP_W-1:0]          two_v;
   logic [CMP_W-1:0]          five_v;
   logic                      same;
   logic [RUN_COUNT_BITS-1:0] len_new;
   close_type                 ca;
   close_type                 cb;
   logic                      fl_emit;
   logic [CHAR_W-1:0]         fl_ch;
   logic [4:0]                emit;
   logic [CHAR_W-1:0]         emit_ch [5];
   logic [1:0]                n;

   always_comb begin
      two_v  = CMP_W'({units, 1'b0});
      five_v = CMP_W'({units, 2'b00}) + CMP_W'(units);
      same   = started && (item.tone_on == level);

      len_new = same ? ((length == '1) ? length : length + RUN_COUNT_BITS'(1))
                     : RUN_COUNT_BITS'(1);

      // old run ends on a level change
      ca = close_run(level, CMP_W'(length), two_v, five_v, pbits, pcnt);
      if (!(started && !same)) begin
         ca.bits       = pbits;
         ca.cnt        = pcnt;
         ca.emit_char  = 1'b0;
         ca.emit_space = 1'b0;
      end

      // end of stream closes the current run, then flushes
      cb = close_run(item.tone_on, CMP_W'(len_new), two_v, five_v, ca.bits, ca.cnt);
      if (!item.end_of_stream) begin
         cb.bits       = ca.bits;
         cb.cnt        = ca.cnt;
         cb.emit_char  = 1'b0;
         cb.emit_space = 1'b0;
      end
      fl_emit = item.end_of_stream && (cb.cnt != '0);
      fl_ch   = decode(cb.bits, cb.cnt);

      emit       = {fl_emit, cb.emit_space, cb.emit_char, ca.emit_space, ca.emit_char};
      emit_ch[0] = ca.ch;
      emit_ch[1] = CHAR_SPACE;
      emit_ch[2] = cb.ch;
      emit_ch[3] = CHAR_SPACE;
      emit_ch[4] = fl_ch;

      result = '0;
      n      = 2'd0;
      for (int k = 0; k < 5; k++) begin
         if (emit[k] && n < 2'(RESULTS_MAX)) begin
            result.items[n].character = emit_ch[k];
            n = n + 2'd1;
         end
      end
      for (int k = 0; k < RESULTS_MAX; k++)
         result.items[k].last_result = (2'(k) == n - 2'd1);
      result.count = n;

      if (item.end_of_stream) begin
         nxt_started = 1'b0;
         nxt_level   = 1'b0;
         nxt_length  = '0;
         nxt_pbits   = '0;
         nxt_pcnt    = '0;
      end else begin
         nxt_started = 1'b1;
         nxt_level   = item.tone_on;
         nxt_length  = len_new;
         nxt_pbits   = ca.bits;
         nxt_pcnt    = ca.cnt;
      end
   end

endmodule

// File: hw/rtl/mtsd_queue.sv
// Result queue: takes up to three items per cycle, hands out one per cycle when popped.
// Shift queue with the head in entry 0; uses mtsd_pkg for the item types.
module mtsd_queue (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [1:0]                                    push_count,
   input  mtsd_pkg::rsp_item_type [mtsd_pkg::RESULTS_MAX-1:0] push_items,
   input  logic                                          pop,
   output logic [2:0]                                    space,
   output logic                                          out_valid,
   output mtsd_pkg::rsp_item_type                        out_item
);
   import mtsd_pkg::*;

   rsp_item_type q_ff [QUEUE_DEPTH];
   rsp_item_type q_in [QUEUE_DEPTH];
   logic [2:0]   count_ff;
   logic [2:0]   count_in;
   logic [2:0]   base;
   logic [2:0]   slot;

   always_comb begin
      q_in = q_ff;
      base = count_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            q_in[i] = q_ff[i + 1];
         base = count_ff - 3'd1;
      end
      for (int k = 0; k < RESULTS_MAX; k++) begin
         slot = base + 3'(k);
         if (2'(k) < push_count)
            q_in[slot[1:0]] = push_items[k];
      end
      count_in = base + 3'(push_count);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign space     = 3'(QUEUE_DEPTH) - count_ff;
   assign out_valid = (count_ff != 3'd0);
   assign out_item  = q_ff[0];

endmodule

// File: hw/rtl/morse_tone_stream_decoder.sv
// Top level of the Morse tone stream decoder: handshakes, state, unit register.
// Instantiates mtsd_step and mtsd_queue; uses mtsd_pkg.
//
//  channel | ports                                 | dir | moves
//  --------+---------------------------------------+-----+-------------------------------
//  req     | req_valid, req_ready, req_item        | in  | one tone sample per item
//  rsp     | rsp_valid, rsp_ready, rsp_item        | out | one decoded character per item
//  csr     | csr_valid, csr_ready, csr_data        | in  | unit length write
//
// One sample item is accepted per cycle while req_ready is high. An accepted item
// is held in the input register, where the decode logic runs, and its results
// (zero to three) enter the four-entry result queue together when it retires;
// with the queue empty, the first then shows on rsp straight from the queue
// register. The queue drains one item per cycle while rsp_ready is high; room
// is judged on its fill before this cycle's pop, so when it lacks room for the
// held item's results that item waits in the input register and req_ready drops.
// Synchronous reset clears run and pattern state, the queue and sets the unit
// length to one. csr_ready is always high.
module morse_tone_stream_decoder #(
   parameter int MAX_ELEMENTS   = 6,
   parameter int RUN_COUNT_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtsd_pkg::req_item_type        req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtsd_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mtsd_pkg::UNITS_W-1:0]  csr_data
);
   import mtsd_pkg::*;

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);

   // unit length register
   logic [UNITS_W-1:0]        units_ff;

   // input register
   logic                      in_valid_ff;
   logic                      in_valid_in;
   req_item_type              in_item_ff;

   // run and pattern state
   logic                      started_ff, started_in;
   logic                      level_ff, level_in;
   logic [RUN_COUNT_BITS-1:0] length_ff, length_in;
   logic [MAX_ELEMENTS-1:0]   pbits_ff, pbits_in;
   logic [CNT_W-1:0]          pcnt_ff, pcnt_in;

   step_result_type           result;
   logic [2:0]                space;
   logic                      move;
   logic                      req_fire;

   mtsd_step #(
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .RUN_COUNT_BITS(RUN_COUNT_BITS),
      .CNT_W         (CNT_W)
   ) u_step (
      .item       (in_item_ff),
      .units      (units_ff),
      .started    (started_ff),
      .level      (level_ff),
      .length     (length_ff),
      .pbits      (pbits_ff),
      .pcnt       (pcnt_ff),
      .nxt_started(started_in),
      .nxt_level  (level_in),
      .nxt_length (length_in),
      .nxt_pbits  (pbits_in),
      .nxt_pcnt   (pcnt_in),
      .result     (result)
   );

   // the held item retires once the queue can take all of its results
   assign move      = in_valid_ff && (space >= 3'(result.count));
   assign req_ready = !in_valid_ff || move;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)
         in_valid_in = 1'b1;
      else if (move)
         in_valid_in = 1'b0;
   end

   mtsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_count(move ? result.count : 2'd0),
      .push_items(result.items),
      .pop       (rsp_valid && rsp_ready),
      .space     (space),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   always_ff @(posedge clock) begin
      if (req_fire)
         in_item_ff <= req_item;
      if (reset) begin
         units_ff    <= UNITS_RESET;
         in_valid_ff <= 1'b0;
         started_ff  <= 1'b0;
         level_ff    <= 1'b0;
         length_ff   <= '0;
         pbits_ff    <= '0;
         pcnt_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_valid && csr_ready)
            units_ff <= csr_data;
         if (move) begin
            started_ff <= started_in;
            level_ff   <= level_in;
            length_ff  <= length_in;
            pbits_ff   <= pbits_in;
            pcnt_ff    <= pcnt_in;
         end
      end
   end

endmodule

// File: hw/rtl/mtsd_checker.sv
// Port-level checks for the Morse tone stream decoder, bound to the top level.
// Uses mtsd_pkg for the result item type.
module mtsd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input mtsd_pkg::rsp_item_type rsp_item
);
   import mtsd_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   // results of one sample are queued together, so a non-last item has a successor
   a_group_whole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_item.last_result |=> rsp_valid)
      else $error("result group broken");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");

endmodule

bind morse_tone_stream_decoder mtsd_checker u_checker (.*);
